// ----- sv/rll_pkg.sv -----
// ----------------------------------------------------------------------------
// rll_pkg
// Shared constants and types of the run-level-last encoder.
// ----------------------------------------------------------------------------
package rll_pkg;

    localparam int BLOCK_LEN   = 64;
    localparam int POS_W       = $clog2(BLOCK_LEN);
    localparam int COEF_W      = 16;
    localparam int RUN_W       = 7;
    localparam int LEVEL_W     = 16;
    localparam int TDATA_IN_W  = ((COEF_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((RUN_W + LEVEL_W + 7) / 8) * 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(BLOCK_LEN - 1);
    // all-zero marker, wraps to the field width
    localparam logic [RUN_W-1:0] ALL_ZERO_RUN = RUN_W'(BLOCK_LEN % (2 ** RUN_W));

    typedef struct packed {
        logic                      last_flag;
        logic signed [LEVEL_W-1:0] level;
        logic        [RUN_W-1:0]   zero_run;
    } t_triple;

    // up to two triples per coefficient, first one goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_triple    first;
        t_triple    second;
    } t_push;

    function automatic logic [RUN_W-1:0] to_run(input logic [POS_W-1:0] v);
        logic [POS_W+RUN_W-1:0] wide;
        wide = {{RUN_W{1'b0}}, v};
        return wide[RUN_W-1:0];
    endfunction

endpackage

// ----- sv/rll_core.sv -----
// ----------------------------------------------------------------------------
// rll_core
// Run and held-triple tracking; emits zero, one or two triples per word.
// ----------------------------------------------------------------------------
module rll_core
    import rll_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic signed [COEF_W-1:0] i_coefficient,
    output t_push                    o_push
);

    logic [POS_W-1:0]          r_position, n_position;
    logic [POS_W-1:0]          r_zero_count, n_zero_count;
    logic                      r_held_valid, n_held_valid;
    logic [POS_W-1:0]          r_held_run, n_held_run;
    logic signed [LEVEL_W-1:0] r_held_level, n_held_level;

    logic    nz;
    logic    blk_end;
    logic    rel_held;
    logic    hv;
    logic [POS_W-1:0] hrun;
    logic signed [LEVEL_W-1:0] hlvl;
    t_triple prev_t;
    t_triple fin_t;

    always_comb begin
        nz       = (i_coefficient != '0);
        blk_end  = (r_position == LAST_POS);
        rel_held = nz && r_held_valid;

        hv   = nz || r_held_valid;
        hrun = nz ? r_zero_count : r_held_run;
        hlvl = nz ? i_coefficient : r_held_level;

        prev_t.zero_run  = to_run(r_held_run);
        prev_t.level     = r_held_level;
        prev_t.last_flag = 1'b0;

        if (hv) begin
            fin_t.zero_run = to_run(hrun);
            fin_t.level    = hlvl;
        end else begin
            fin_t.zero_run = ALL_ZERO_RUN;
            fin_t.level    = '0;
        end
        fin_t.last_flag = 1'b1;

        o_push.cnt    = 2'(i_accept) * (2'(rel_held) + 2'(blk_end));
        o_push.first  = rel_held ? prev_t : fin_t;
        o_push.second = fin_t;

        n_position   = r_position;
        n_zero_count = r_zero_count;
        n_held_valid = r_held_valid;
        n_held_run   = r_held_run;
        n_held_level = r_held_level;
        if (i_accept) begin
            if (blk_end) begin
                n_position   = '0;
                n_zero_count = '0;
                n_held_valid = 1'b0;
                n_held_run   = '0;
                n_held_level = '0;
            end else begin
                n_position   = r_position + 1'b1;
                n_zero_count = nz ? '0 : r_zero_count + 1'b1;
                n_held_valid = hv;
                n_held_run   = hrun;
                n_held_level = hlvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_zero_count <= '0;
            r_held_valid <= 1'b0;
            r_held_run   <= '0;
            r_held_level <= '0;
        end else begin
            r_position   <= n_position;
            r_zero_count <= n_zero_count;
            r_held_valid <= n_held_valid;
            r_held_run   <= n_held_run;
            r_held_level <= n_held_level;
        end
    end

endmodule

// ----- sv/rll_out_fifo.sv -----
// ----------------------------------------------------------------------------
// rll_out_fifo
// Small flop queue of result triples, two writes and one read per cycle.
// ----------------------------------------------------------------------------
module rll_out_fifo
    import rll_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room2,
    output logic    o_valid,
    output t_triple o_head
);

    t_triple          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wptr1;

    assign wptr1   = r_wptr + 1'b1;
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr + PTR_W'(i_push.cnt);
        n_rptr  = r_rptr + PTR_W'(i_pop);
        n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wptr1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/run_level_last_encoder.sv -----
// ----------------------------------------------------------------------------
// run_level_last_encoder
// Run-level-last coding of 8x8 coefficient blocks.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit coefficient per cycle in raster order, 64 per
// block, and emits a word (zero_run, level, last) for each nonzero
// coefficient; the last nonzero of a block carries tlast, an all-zero block
// gives the single word (64, 0, last). A word that a coefficient releases is
// registered into a four-entry output queue and leaves from its head.
// The input stays ready while the queue has room for two words, so a
// coefficient can enter every cycle as long as the sink takes words; the
// final coefficient of a block may produce two words at once.
module run_level_last_encoder
    import rll_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,   // [15:0] coefficient
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,   // [6:0] zero_run, [22:7] level
    output logic                   o_m_axis_tlast    // last_flag
);

    logic    accept;
    logic    pop;
    logic    room2;
    t_push   push;
    t_triple head;

    assign accept          = i_s_axis_tvalid && room2;
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = room2;

    rll_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_coefficient (i_s_axis_tdata[COEF_W-1:0]),
        .o_push        (push)
    );

    rll_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room2 (room2),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head)
    );

    assign o_m_axis_tdata = TDATA_OUT_W'({head.level, head.zero_run});
    assign o_m_axis_tlast = head.last_flag;

endmodule

// ----- sv/rll_checker.sv -----
// ----------------------------------------------------------------------------
// rll_checker
// Port-level checks of the run-level-last encoder.
// ----------------------------------------------------------------------------
module rll_checker
    import rll_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [TDATA_IN_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [TDATA_OUT_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tlast
);

    logic [RUN_W-1:0]   w_run;
    logic [LEVEL_W-1:0] w_level;

    assign w_run   = o_m_axis_tdata[RUN_W-1:0];
    assign w_level = o_m_axis_tdata[RUN_W+LEVEL_W-1:RUN_W];

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    // only the closing word may carry a zero level
    a_nonlast_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> w_level != '0)
        else $error("non-final word with zero level");

    a_zero_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_level == '0 |-> o_m_axis_tlast && w_run == ALL_ZERO_RUN)
        else $error("zero level without all-zero marker");

    // empty output queue always leaves the input open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind run_level_last_encoder rll_checker u_rll_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- test/run_level_last_encoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_level_last_encoder_test
// Self-checking bench for the run-level-last block encoder.
// ----------------------------------------------------------------------------
// Streams whole blocks of coefficients into the encoder and checks every
// output word against a local encoder model run on each accepted
// coefficient. A short table of blocks covers all-zero blocks, extreme
// levels and runs, two words from the final coefficient and fully dense
// blocks. Random blocks of mixed density follow. The source sends in bursts
// and the sink stalls on its own pattern, with one long sink hold-off and
// source pauses that let the output drain completely.
// ----------------------------------------------------------------------------
module run_level_last_encoder_test
    import rll_pkg::*;
();

    // the directed table already sends ten blocks
    localparam int RAND_ITEMS       = 210;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 16;
    localparam int IDLE_LIMIT       = 4000;

    typedef enum logic [0:0] {BLK_SPARSE, BLK_DENSE} t_blk_kind;

    // SPARSE: nonzero only at pos_a/pos_b (a zero value means none)
    // DENSE:  val_a at even positions, val_b at odd positions
    typedef struct {
        t_blk_kind         kind;
        int                pos_a;
        logic [COEF_W-1:0] val_a;
        int                pos_b;
        logic [COEF_W-1:0] val_b;
        bit                typed;
        t_triple           exp_word;
    } t_blk_row;

    localparam t_triple NO_WORD = '0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [TDATA_IN_W-1:0]  i_s_axis_tdata;   // [15:0] coefficient
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [TDATA_OUT_W-1:0] o_m_axis_tdata;   // [6:0] zero_run, [22:7] level
    logic                   o_m_axis_tlast;   // last_flag

    logic in_fire;
    logic out_fire;

    // words the encoder still owes, oldest first
    t_triple exp_words [$];

    // local encoder state
    int                        coef_pos;
    int                        zero_cnt;
    bit                        pend_valid;
    logic        [RUN_W-1:0]   pend_run;
    logic signed [LEVEL_W-1:0] pend_level;

    // tags that travel with the word on the input bus
    bit      cur_typed;
    t_triple cur_exp;

    bit sink_hold_req;
    int burst_left;
    int errors;
    int idle_cycles;

    t_blk_row dir_rows [10] = '{
        '{BLK_SPARSE, 0, 16'h0000, 0, 16'h0000, 1'b1,
          '{last_flag: 1'b1, level: 16'sh0000, zero_run: RUN_W'(BLOCK_LEN)}},
        '{BLK_SPARSE, 0, 16'h7FFF, 0, 16'h0000, 1'b1,
          '{last_flag: 1'b1, level: 16'sh7FFF, zero_run: RUN_W'(0)}},
        '{BLK_SPARSE, BLOCK_LEN - 1, 16'h8000, 0, 16'h0000, 1'b1,
          '{last_flag: 1'b1, level: 16'sh8000, zero_run: RUN_W'(BLOCK_LEN - 1)}},
        '{BLK_SPARSE, 0, 16'hFFFF, 0, 16'h0000, 1'b1,
          '{last_flag: 1'b1, level: 16'shFFFF, zero_run: RUN_W'(0)}},
        '{BLK_SPARSE, BLOCK_LEN - 1, 16'h0001, 0, 16'h0000, 1'b1,
          '{last_flag: 1'b1, level: 16'sh0001, zero_run: RUN_W'(BLOCK_LEN - 1)}},
        '{BLK_SPARSE, 0, 16'h8000, BLOCK_LEN - 1, 16'h7FFF, 1'b0, NO_WORD},
        '{BLK_SPARSE, 5, 16'h5555, 40, 16'hAAAA, 1'b0, NO_WORD},
        '{BLK_DENSE, 0, 16'h8000, 0, 16'h7FFF, 1'b0, NO_WORD},
        '{BLK_DENSE, 0, 16'hFFFF, 0, 16'h0001, 1'b0, NO_WORD},
        '{BLK_SPARSE, 0, 16'h0000, 0, 16'h0000, 1'b1,
          '{last_flag: 1'b1, level: 16'sh0000, zero_run: RUN_W'(BLOCK_LEN)}}
    };

    run_level_last_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    // Encodes one coefficient and queues the words it releases. A typed row
    // supplies its own expected word in place of the computed one.
    task automatic encode_coef(input logic [COEF_W-1:0] coef, input bit typed,
                               input t_triple typed_word);
        t_triple words [2];
        int      n;
        n = 0;
        if (coef != '0) begin
            if (pend_valid) begin
                words[n] = '{last_flag: 1'b0, level: pend_level, zero_run: pend_run};
                n++;
            end
            pend_valid = 1'b1;
            pend_run   = RUN_W'(zero_cnt);
            pend_level = coef;
            zero_cnt   = 0;
        end else begin
            zero_cnt++;
        end
        coef_pos++;
        if (coef_pos >= BLOCK_LEN) begin
            if (pend_valid)
                words[n] = '{last_flag: 1'b1, level: pend_level, zero_run: pend_run};
            else
                words[n] = '{last_flag: 1'b1, level: '0, zero_run: RUN_W'(BLOCK_LEN)};
            n++;
            coef_pos   = 0;
            zero_cnt   = 0;
            pend_valid = 1'b0;
            pend_run   = '0;
            pend_level = '0;
        end
        if (typed && n != 0)
            exp_words.push_back(typed_word);
        else
            for (int i = 0; i < n; i++)
                exp_words.push_back(words[i]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_fire)
            encode_coef(i_s_axis_tdata[COEF_W-1:0], cur_typed, cur_exp);
    end

    always @(posedge i_clk) begin : out_check
        t_triple got;
        t_triple want;
        if (i_rst_n && out_fire) begin
            got.zero_run  = o_m_axis_tdata[RUN_W-1:0];
            got.level     = o_m_axis_tdata[RUN_W +: LEVEL_W];
            got.last_flag = o_m_axis_tlast;
            if (exp_words.size() == 0) begin
                $error("unexpected word: zero_run %0d level %0d last %0b",
                       got.zero_run, got.level, got.last_flag);
                errors++;
            end else begin
                want = exp_words.pop_front();
                if (got.zero_run !== want.zero_run) begin
                    $error("zero_run: expected %0d, got %0d", want.zero_run, got.zero_run);
                    errors++;
                end
                if (got.level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, got.level);
                    errors++;
                end
                if (got.last_flag !== want.last_flag) begin
                    $error("last_flag: expected %0b, got %0b", want.last_flag,
                           got.last_flag);
                    errors++;
                end
            end
        end
    end

    // no word moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sink: stall pattern of its own, plus one long hold-off on request
    initial begin : sink
        int mode;
        int span;
        i_m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span) begin
                @(negedge i_clk);
                if (sink_hold_req) begin
                    i_m_axis_tready <= 1'b0;
                    for (int c = 1; c < SINK_HOLD_CYCLES; c++)
                        @(negedge i_clk);
                    sink_hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: i_m_axis_tready <= 1'b1;
                        1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                        2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // Offers one coefficient and returns once it is taken. Source runs in
    // bursts with random gaps, some with no gap at all.
    task automatic send_coef(input logic [COEF_W-1:0] coef, input bit typed,
                             input t_triple typed_word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= coef;
        cur_typed       <= typed;
        cur_exp         <= typed_word;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
    endtask

    // source holds off until every owed word is out
    task automatic drain_pause();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (exp_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] rand_level();
        logic [COEF_W-1:0] v;
        if ($urandom_range(0, 9) < 7) begin
            v = COEF_W'($urandom_range(1, 31));
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end else begin
            v = COEF_W'($urandom);
            if (v == '0)
                v = 16'h8000;
        end
        return v;
    endfunction

    initial begin : stim
        logic [COEF_W-1:0] coef;
        int                density;
        int                blk;
        int                sent;
        int                k;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        cur_typed       = 1'b0;
        cur_exp         = '0;
        sink_hold_req   = 1'b0;
        burst_left      = 0;
        errors          = 0;
        idle_cycles     = 0;
        coef_pos        = 0;
        zero_cnt        = 0;
        pend_valid      = 1'b0;
        pend_run        = '0;
        pend_level      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            for (int p = 0; p < BLOCK_LEN; p++) begin
                if (dir_rows[r].kind == BLK_DENSE)
                    coef = p[0] ? dir_rows[r].val_b : dir_rows[r].val_a;
                else if (p == dir_rows[r].pos_a)
                    coef = dir_rows[r].val_a;
                else if (p == dir_rows[r].pos_b)
                    coef = dir_rows[r].val_b;
                else
                    coef = '0;
                send_coef(coef, dir_rows[r].typed, dir_rows[r].exp_word);
            end
        end
        drain_pause();

        // random blocks; density 0 is an all-zero block, 3 is nearly full
        blk  = 0;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (blk == 2)
                sink_hold_req = 1'b1;
            case ($urandom_range(0, 9))
                0:       density = 0;
                1, 2, 3: density = 1;
                4, 5, 6: density = 2;
                default: density = 3;
            endcase
            for (int p = 0; p < BLOCK_LEN; p++) begin
                case (density)
                    0:       coef = '0;
                    1:       coef = ($urandom_range(0, 15) == 0) ? rand_level() : '0;
                    2:       coef = ($urandom_range(0, 1) == 0) ? rand_level() : '0;
                    default: coef = ($urandom_range(0, 7) != 0) ? rand_level() : '0;
                endcase
                // mid-block drain: any held word stays inside the encoder
                if (blk == 1 && p == BLOCK_LEN / 2)
                    drain_pause();
                send_coef(coef, 1'b0, NO_WORD);
                sent++;
            end
            blk++;
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        for (k = 0; k < IDLE_LIMIT && exp_words.size() != 0; k++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (exp_words.size() != 0) begin
            $error("%0d expected words never came out", exp_words.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rll_pkg.sv
sv/rll_core.sv
sv/rll_out_fifo.sv
sv/run_level_last_encoder.sv
sv/rll_checker.sv
test/run_level_last_encoder_test.sv
